### rtl/core/wtm_pkg.sv
// ----------------------------------------------------------------------------
// wtm_pkg: shared types and constants of the wildcard text matcher
// Payload structs, register indexes, byte codes and default sizes.
// ----------------------------------------------------------------------------
package wtm_pkg;

	// default sizes
	localparam int MAX_PATTERN_DEF = 16;
	localparam int COUNT_BITS_DEF  = 32;

	// register file layout
	localparam int PAT_BYTES = 16;
	localparam int PAT_W     = PAT_BYTES * 8;
	localparam int CFG_W     = 64;
	localparam int LEN_W     = 5;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 2'd2;

	// byte codes
	localparam logic [7:0] WILDCARD_BYTE = 8'd63;
	localparam logic [7:0] NEWLINE_BYTE  = 8'd10;

	typedef struct packed {
		logic [7:0] text_byte;
		logic       text_start;
	} text_item_t;

	typedef struct packed {
		logic [31:0] line_number;
		logic [31:0] start_column;
		logic [63:0] matched_low;
		logic [63:0] matched_high;
	} match_item_t;

	typedef struct packed {
		logic        hit;
		match_item_t item;
	} match_t;

endpackage

### rtl/core/wtm_match.sv
// ----------------------------------------------------------------------------
// wtm_match: window compare
// Compares the newest pattern_length window bytes with the pattern, wildcard
// aware, and forms the result fields.
// ----------------------------------------------------------------------------
module wtm_match import wtm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic [MAX_PATTERN*8-1:0] window,
	input  logic [COUNT_BITS-1:0]    line_bytes_seen,
	input  logic [COUNT_BITS-1:0]    line_count,
	input  logic [PAT_W-1:0]         pattern,
	input  logic [LEN_W-1:0]         pattern_length,
	output match_t                   match
);

	localparam int LANES = (MAX_PATTERN < PAT_BYTES) ? MAX_PATTERN : PAT_BYTES;
	localparam int IDX_W = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int EXT_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

	always_comb begin
		logic [LEN_W-1:0]      len;
		logic [LEN_W-1:0]      idx;
		logic [7:0]            tb;
		logic [7:0]            pb;
		logic                  ok;
		logic [PAT_W-1:0]      matched;
		logic [COUNT_BITS-1:0] start;
		logic [EXT_W-1:0]      start_ext;
		logic [EXT_W-1:0]      count_ext;

		// clamp length into 1..LANES
		if (pattern_length == '0) begin
			len = LEN_W'(1);
		end else if (pattern_length > LEN_W'(LANES)) begin
			len = LEN_W'(LANES);
		end else begin
			len = pattern_length;
		end

		ok      = 1'b1;
		matched = '0;
		for (int i = 0; i < LANES; i++) begin
			// pattern byte i lines up with window byte len-1-i (0 is newest)
			idx = len - LEN_W'(i + 1);
			tb  = window[8 * int'(idx[IDX_W-1:0]) +: 8];
			pb  = pattern[8 * i +: 8];
			if (LEN_W'(i) < len) begin
				if (pb != WILDCARD_BYTE && pb != tb) begin
					ok = 1'b0;
				end
				matched[8 * i +: 8] = tb;
			end
		end

		start     = line_bytes_seen - COUNT_BITS'(len);
		start_ext = EXT_W'(start);
		count_ext = EXT_W'(line_count);

		match.hit               = ok && (line_bytes_seen >= COUNT_BITS'(len));
		match.item.line_number  = count_ext[31:0];
		match.item.start_column = start_ext[31:0];
		match.item.matched_low  = matched[63:0];
		match.item.matched_high = matched[127:64];
	end

endmodule

### rtl/core/wildcard_text_matcher.sv
// ----------------------------------------------------------------------------
// wildcard_text_matcher: streaming wildcard pattern search
// Scans text one byte per transaction and reports every place where the
// current line holds the configured pattern ('?' matches any byte).
// ----------------------------------------------------------------------------
// usage
//  - config: cfg_wr_en writes cfg_data to register cfg_addr (0 pattern bytes
//    0..7, 1 pattern bytes 8..15, 2 pattern length); write only while idle
//  - input channel in_valid/in_ready carries one text byte per transaction;
//    text_start restarts the line count and clears the window first
//  - output channel out_valid/out_ready carries one match per transaction:
//    line number from 1, start column from 0 and the matched bytes
//  - a byte updates window and counters at its accept edge; the compare runs
//    in the following cycle and the result is registered, so a match passes
//    through the compare stage and the result register before out_valid
//  - throughput is one byte per cycle while the receiver keeps out_ready high;
//    the window compare and the result register set this figure
//  - a stalled receiver holds the result register; the compare stage then
//    stalls and in_ready drops only once both are occupied
//  - reset clears the window and column count, sets line count to one,
//    pattern bytes to zero and pattern length to one
//  - newline bytes produce no match; counters saturate
// ----------------------------------------------------------------------------
module wildcard_text_matcher import wtm_pkg::*; #(
	parameter int MAX_PATTERN = MAX_PATTERN_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]     cfg_data,
	// text in
	input  logic                 in_valid,
	output logic                 in_ready,
	input  text_item_t           in_item,
	// matches out
	output logic                 out_valid,
	input  logic                 out_ready,
	output match_item_t          out_item
);

	localparam int WIN_W = MAX_PATTERN * 8;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	// configuration registers
	logic [CFG_W-1:0] pattern_low_q;
	logic [CFG_W-1:0] pattern_high_q;
	logic [LEN_W-1:0] pattern_len_q;

	// line state, byte 0 of the window is the newest
	logic [WIN_W-1:0]      window_q;
	logic [COUNT_BITS-1:0] seen_q;
	logic [COUNT_BITS-1:0] line_count_q;

	// compare stage and result register
	logic        valid_s1;
	logic        data_s1;
	logic        valid_s2;
	match_item_t item_s2;

	logic   in_fire;
	logic   s1_go;
	match_t match;

	// compare stage moves on when the result register is free or being taken
	assign s1_go    = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || s1_go;
	assign in_fire  = in_valid && in_ready;

	// config writes, out of range indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			pattern_len_q  <= LEN_W'(1);
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				CFG_PATTERN_LOW:  pattern_low_q  <= cfg_data;
				CFG_PATTERN_HIGH: pattern_high_q <= cfg_data;
				CFG_PATTERN_LEN:  pattern_len_q  <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// line state update at each accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		logic [WIN_W-1:0]      win_base;
		logic [COUNT_BITS-1:0] seen_base;
		logic [COUNT_BITS-1:0] count_base;
		if (!arst_n) begin
			window_q     <= '0;
			seen_q       <= '0;
			line_count_q <= COUNT_BITS'(1);
		end else if (in_fire) begin
			// text start wipes the line before the byte is taken
			win_base   = in_item.text_start ? '0 : window_q;
			seen_base  = in_item.text_start ? '0 : seen_q;
			count_base = in_item.text_start ? COUNT_BITS'(1) : line_count_q;
			if (in_item.text_byte == NEWLINE_BYTE) begin
				window_q     <= '0;
				seen_q       <= '0;
				line_count_q <= (count_base == COUNT_MAX) ? count_base
				                                          : count_base + COUNT_BITS'(1);
			end else begin
				window_q     <= WIN_W'({win_base, in_item.text_byte});
				seen_q       <= (seen_base == COUNT_MAX) ? seen_base
				                                         : seen_base + COUNT_BITS'(1);
				line_count_q <= count_base;
			end
		end
	end

	// compare stage: state registers already hold this byte's view
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			data_s1  <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
			data_s1  <= (in_item.text_byte != NEWLINE_BYTE);
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	wtm_match #(
		.MAX_PATTERN (MAX_PATTERN),
		.COUNT_BITS  (COUNT_BITS)
	) u_match (
		.window          (window_q),
		.line_bytes_seen (seen_q),
		.line_count      (line_count_q),
		.pattern         ({pattern_high_q, pattern_low_q}),
		.pattern_length  (pattern_len_q),
		.match           (match)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (valid_s1 && data_s1 && s1_go && match.hit) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && data_s1 && s1_go && match.hit) begin
			item_s2 <= match.item;
		end
	end

	assign out_valid = valid_s2;
	assign out_item  = item_s2;

	// a hit leaving the compare stage always lands in the result register
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && data_s1 && s1_go && match.hit) |=> valid_s2)
		else $error("match lost between compare stage and result register");

	// a newline leaves an empty line behind
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_item.text_byte == NEWLINE_BYTE) |=>
		(seen_q == '0 && window_q == '0))
		else $error("newline did not clear the line state");

	// text start on an ordinary byte restarts at line one
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_item.text_start && in_item.text_byte != NEWLINE_BYTE) |=>
		(line_count_q == COUNT_BITS'(1) && seen_q == COUNT_BITS'(1)))
		else $error("text start did not restart the counters");

	// a stalled result blocks the compare stage from dropping its byte
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_go) |=> valid_s1)
		else $error("compare stage dropped a byte while stalled");

endmodule

### bench/tb_wildcard_text_matcher.sv
// ----------------------------------------------------------------------------
// tb_wildcard_text_matcher: self-checking bench of the wildcard text matcher
// A table of directed text runs at reset defaults and the pattern extremes.
// Random pattern settings with seeded matches follow, with bursty input and
// a stalling receiver. A local scanner predicts every match, and each
// accepted match is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_wildcard_text_matcher;
	import wtm_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 6;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int IDLE_TAIL    = 6;   // compare stage plus result register, with margin
	localparam int N_SETTINGS   = 10;
	localparam int BYTES_PER_SETTING = 140;
	localparam int MAX_REPORTS  = 10;
	localparam int WIN_DEPTH    = MAX_PATTERN_DEF;

	// address past the register list, writes there must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	// receiver behavior, picked per stretch of cycles
	typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_BLOCK} rx_mode_t;

	// one row of the directed table: a register write or a text byte
	typedef struct {
		bit                   is_cfg;
		logic [CFG_IDX_W-1:0] addr;
		logic [CFG_W-1:0]     data;
		text_item_t           text;
		bit                   typed;      // expected outcome typed into the row
		bit                   has_match;
		match_item_t          want;
	} dir_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_addr = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	text_item_t           in_item = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	match_item_t          out_item;

	// scanner state, mirrors the block
	logic [7:0]  win [WIN_DEPTH];
	logic [31:0] col_seen;
	logic [31:0] line_no;
	logic [63:0] pat_lo;
	logic [63:0] pat_hi;
	logic [4:0]  pat_len;

	match_item_t pending_matches[$];
	dir_row_t    directed_rows[$];

	int n_fail = 0;
	int n_matches = 0;
	int n_bytes = 0;
	int n_settings = 0;
	int cycles = 0;
	int burst_left = 0;

	wildcard_text_matcher DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// scanner: pattern access, window update and match prediction
	// ------------------------------------------------------------------

	// pattern length in use: zero reads as one, anything past 16 saturates
	function automatic int eff_len();
		int n;
		n = (pat_len == 0) ? 1 : int'(pat_len);
		if (n > PAT_BYTES) n = PAT_BYTES;
		if (n > WIN_DEPTH) n = WIN_DEPTH;
		return n;
	endfunction

	function automatic logic [7:0] pat_byte(input int i);
		return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
	endfunction

	function automatic void clear_line();
		int i;
		for (i = 0; i < WIN_DEPTH; i++) win[i] = 8'h00;
		col_seen = '0;
	endfunction

	// takes one accepted text byte, returns 1 with the match it causes
	function automatic bit scan_byte(input text_item_t it, output match_item_t m);
		int         i;
		int         n;
		int         base;
		logic [7:0] p;
		logic [7:0] t;
		m = '0;
		if (it.text_start) begin
			clear_line();
			line_no = 32'd1;
		end
		// newline closes the line and never matches, even against a wildcard
		if (it.text_byte == NEWLINE_BYTE) begin
			clear_line();
			if (line_no != '1) line_no++;
			return 1'b0;
		end
		for (i = 0; i < WIN_DEPTH - 1; i++) win[i] = win[i+1];
		win[WIN_DEPTH-1] = it.text_byte;
		if (col_seen != '1) col_seen++;
		n = eff_len();
		// line still shorter than the pattern
		if (col_seen < n) return 1'b0;
		base = WIN_DEPTH - n;
		for (i = 0; i < n; i++) begin
			p = pat_byte(i);
			t = win[base+i];
			if (p != WILDCARD_BYTE && p != t) return 1'b0;
			if (i < 8) m.matched_low[8*i +: 8] = t;
			else m.matched_high[8*(i-8) +: 8] = t;
		end
		m.line_number  = line_no;
		m.start_column = col_seen - n;
		return 1'b1;
	endfunction

	// queue a predicted match behind the ones still owed
	function automatic void owe_match(input match_item_t m);
		pending_matches.insert(pending_matches.size(), m);
	endfunction

	// ------------------------------------------------------------------
	// drivers
	// ------------------------------------------------------------------

	// register write, left asserted; the caller lowers cfg_wr_en after a sequence
	task automatic write_reg(input logic [CFG_IDX_W-1:0] addr, input logic [CFG_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= addr;
		cfg_data  <= data;
		@(posedge clk);
		case (addr)
			CFG_PATTERN_LOW:  pat_lo = data;
			CFG_PATTERN_HIGH: pat_hi = data;
			CFG_PATTERN_LEN:  pat_len = data[LEN_W-1:0];
			default: ;
		endcase
	endtask

	// drop valid and wait until every predicted match is out, plus the
	// pipeline tail since the last bytes may still be in the compare stage
	task automatic settle_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_matches.size() != 0) @(posedge clk);
		repeat (IDLE_TAIL) @(posedge clk);
	endtask

	// one input transaction; the sender runs in bursts with gaps between,
	// and now and then a long burst with no gaps at all
	task automatic push_text(input text_item_t it);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
			                                         : $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_item  <= it;
		do @(posedge clk); while (!in_ready);
		n_bytes++;
	endtask

	task automatic send_byte(input logic [7:0] b, input bit s);
		text_item_t  it;
		match_item_t m;
		it.text_byte  = b;
		it.text_start = s;
		push_text(it);
		if (scan_byte(it, m)) owe_match(m);
	endtask

	// receiver: stretches of always ready, coin flips, mostly ready, or a
	// block stall that opens only near the end of the stretch
	always @(posedge clk) begin : rx_stall
		rx_mode_t mode;
		int       left;
		if (left <= 0) begin
			mode = rx_mode_t'($urandom_range(0, 3));
			left = $urandom_range(4, 40);
		end
		left--;
		case (mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
			RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
			default:   out_ready <= (left < 4);
		endcase
	end

	// ------------------------------------------------------------------
	// checking
	// ------------------------------------------------------------------

	task automatic note_fail(input string msg);
		n_fail++;
		if (n_fail <= MAX_REPORTS) $display("mismatch: %s", msg);
	endtask

	// every accepted output transaction against the oldest prediction
	always @(posedge clk) begin : match_check
		match_item_t want;
		if (arst_n && out_valid && out_ready) begin
			n_matches++;
			if (pending_matches.size() == 0) begin
				note_fail($sformatf("unexpected match, line %0d column %0d",
					out_item.line_number, out_item.start_column));
			end else begin
				want = pending_matches.pop_front();
				if (want.line_number !== out_item.line_number)
					note_fail($sformatf("match %0d line_number expected %0d got %0d",
						n_matches, want.line_number, out_item.line_number));
				if (want.start_column !== out_item.start_column)
					note_fail($sformatf("match %0d start_column expected %0d got %0d",
						n_matches, want.start_column, out_item.start_column));
				if (want.matched_low !== out_item.matched_low)
					note_fail($sformatf("match %0d matched_low expected %h got %h",
						n_matches, want.matched_low, out_item.matched_low));
				if (want.matched_high !== out_item.matched_high)
					note_fail($sformatf("match %0d matched_high expected %h got %h",
						n_matches, want.matched_high, out_item.matched_high));
			end
		end
	end

	// hard stop if the handshakes hang
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d matches still owed",
				cycles, pending_matches.size());
			$display("status: fail");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------

	function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] addr,
	                                     input logic [CFG_W-1:0] data);
		dir_row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.addr   = addr;
		r.data   = data;
		return r;
	endfunction

	// byte checked against the scanner only
	function automatic dir_row_t row_text(input logic [7:0] b, input bit s);
		dir_row_t r;
		r = '{default: '0};
		r.text.text_byte  = b;
		r.text.text_start = s;
		return r;
	endfunction

	// byte that must give no match
	function automatic dir_row_t row_none(input logic [7:0] b, input bit s);
		dir_row_t r;
		r = row_text(b, s);
		r.typed = 1'b1;
		return r;
	endfunction

	// byte with its match typed in
	function automatic dir_row_t row_match(input logic [7:0] b, input bit s,
	                                       input logic [31:0] ln, input logic [31:0] col,
	                                       input logic [63:0] lo, input logic [63:0] hi);
		dir_row_t r;
		r = row_none(b, s);
		r.has_match = 1'b1;
		r.want = '{line_number: ln, start_column: col, matched_low: lo, matched_high: hi};
		return r;
	endfunction

	// append one row to the table
	function automatic void add_row(input dir_row_t r);
		directed_rows.insert(directed_rows.size(), r);
	endfunction

	task automatic build_directed();
		int i;
		// reset pattern is a single zero byte
		add_row(row_match(8'h00, 1'b0, 32'd1, 32'd0, 64'h0, 64'h0));
		add_row(row_none(8'hFF, 1'b0));
		add_row(row_none(NEWLINE_BYTE, 1'b0));
		add_row(row_match(8'h00, 1'b0, 32'd2, 32'd0, 64'h0, 64'h0));
		// text start puts the line count back to one
		add_row(row_match(8'h00, 1'b1, 32'd1, 32'd0, 64'h0, 64'h0));
		// lone wildcard, pattern length zero reads as one
		add_row(row_cfg(CFG_PATTERN_LOW, 64'(WILDCARD_BYTE)));
		add_row(row_cfg(CFG_PATTERN_LEN, 64'd0));
		add_row(row_match(8'hFF, 1'b1, 32'd1, 32'd0, 64'hFF, 64'h0));
		add_row(row_match(WILDCARD_BYTE, 1'b0, 32'd1, 32'd1,
			64'(WILDCARD_BYTE), 64'h0));
		add_row(row_none(NEWLINE_BYTE, 1'b0));
		// sixteen wildcards, length 31 saturates to 16; the stray write past
		// the register list would otherwise shrink the pattern
		add_row(row_cfg(CFG_PATTERN_LOW, {8{WILDCARD_BYTE}}));
		add_row(row_cfg(CFG_PATTERN_HIGH, {8{WILDCARD_BYTE}}));
		add_row(row_cfg(CFG_PATTERN_LEN, 64'd31));
		add_row(row_cfg(CFG_UNUSED, 64'd1));
		// short line: nothing until the sixteenth byte
		for (i = 0; i < 15; i++) add_row(row_none(8'(i * 17), i == 0));
		add_row(row_match(8'hFF, 1'b0, 32'd1, 32'd0,
			64'h7766554433221100, 64'hFFEEDDCCBBAA9988));
		// overlapping match one column on
		add_row(row_text(8'h00, 1'b0));
	endtask

	task automatic run_directed();
		int          k;
		dir_row_t    r;
		match_item_t m;
		bit          hit;
		for (k = 0; k < directed_rows.size(); k++) begin
			r = directed_rows[k];
			if (r.is_cfg) begin
				if (k == 0 || !directed_rows[k-1].is_cfg) begin
					settle_idle();
					n_settings++;
				end
				write_reg(r.addr, r.data);
				if (k + 1 == directed_rows.size() || !directed_rows[k+1].is_cfg)
					cfg_wr_en <= 1'b0;
			end else begin
				push_text(r.text);
				hit = scan_byte(r.text, m);
				if (r.typed) begin
					hit = r.has_match;
					m   = r.want;
				end
				if (hit) owe_match(m);
			end
		end
	endtask

	// ------------------------------------------------------------------
	// random part
	// ------------------------------------------------------------------

	// small alphabet so that random text hits the pattern now and then
	function automatic logic [7:0] letter();
		return 8'h61 + 8'($urandom_range(0, 2));   // 'a'..'c'
	endfunction

	// new pattern setting: the first three phases take length 1, 16 and a
	// saturating 31, the rest are mostly short
	task automatic new_setting(input int p);
		logic [7:0]       pb [PAT_BYTES];
		logic [LEN_W-1:0] len;
		logic [63:0]      lo;
		logic [63:0]      hi;
		int               i;
		int               r;
		for (i = 0; i < PAT_BYTES; i++) begin
			r = $urandom_range(0, 9);
			if (r < 3) pb[i] = WILDCARD_BYTE;
			else if (r < 9) pb[i] = letter();
			else pb[i] = 8'($urandom_range(0, 255));
		end
		for (i = 0; i < 8; i++) begin
			lo[8*i +: 8] = pb[i];
			hi[8*i +: 8] = pb[i+8];
		end
		r = $urandom_range(0, 9);
		if (p == 0) len = 5'd1;
		else if (p == 1) len = 5'd16;
		else if (p == 2) len = 5'd31;
		else if (r < 7) len = 5'($urandom_range(2, 6));
		else if (r < 9) len = 5'($urandom_range(7, 16));
		else len = 5'($urandom_range(0, 31));
		settle_idle();
		n_settings++;
		// junk above the length field must be ignored
		write_reg(CFG_PATTERN_LEN, {32'($urandom()), 27'($urandom()), len});
		write_reg(CFG_PATTERN_LOW, lo);
		write_reg(CFG_PATTERN_HIGH, hi);
		if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, {$urandom(), $urandom()});
		cfg_wr_en <= 1'b0;
	endtask

	// text mostly made of planted pattern copies and alphabet bytes, with
	// raw bytes, newlines and text starts as noise
	task automatic run_text(input int n);
		int         sent;
		int         i;
		int         r;
		logic [7:0] b;
		sent = 0;
		while (sent < n) begin
			r = $urandom_range(0, 99);
			if (r < 45) begin
				for (i = 0; i < eff_len(); i++) begin
					b = pat_byte(i);
					if (b == WILDCARD_BYTE)
						b = $urandom_range(0, 1) ? letter() : 8'($urandom_range(0, 255));
					send_byte(b, 1'b0);
					sent++;
				end
			end else begin
				if (r < 80) send_byte(letter(), 1'b0);
				else if (r < 92) send_byte(8'($urandom_range(0, 255)), 1'b0);
				else if (r < 98) send_byte(NEWLINE_BYTE, 1'b0);
				else send_byte(($urandom_range(0, 1) ? letter() : 8'($urandom_range(0, 255))),
					1'b1);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin : main
		int p;
		clear_line();
		line_no = 32'd1;
		pat_lo  = '0;
		pat_hi  = '0;
		pat_len = 5'd1;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		build_directed();
		run_directed();

		for (p = 0; p < N_SETTINGS; p++) begin
			new_setting(p);
			run_text(BYTES_PER_SETTING);
		end

		settle_idle();
		$display("run: %0d text bytes over %0d pattern settings, %0d matches, %0d cycles",
			n_bytes, n_settings, n_matches, cycles);
		$display("      lengths 0, 1, 16 and saturating, wildcards, newlines, text starts");
		if (n_fail == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches", n_fail);
			$display("status: fail");
		end
		$finish;
	end

endmodule
